// File: hdl/ffa_pkg.sv
package ffa_pkg;

    // Default pool geometry
    localparam int HEAP_UNITS_DEF = 4096;
    localparam int UNIT_BYTES_DEF = 16;

    // Fixed field widths
    localparam int BYTES_W    = 16;
    localparam int ADDR_W     = 12;
    localparam int MIN_GROW_W = 13;
    localparam int NEED_W     = 17;

    localparam logic [MIN_GROW_W-1:0] MIN_GROW_RST = 13'd1024;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [BYTES_W-1:0]   request_bytes;
        logic [ADDR_W-1:0]    block_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic              ok;
    } rsp_t;

endpackage

// File: hdl/ffa_ram.sv
module ffa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/ffa_core.sv
module ffa_core #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  ffa_pkg::req_t                    req,
    input  logic [ffa_pkg::MIN_GROW_W-1:0]   min_grow,
    output logic                             res_valid,
    input  logic                             res_ready,
    output ffa_pkg::rsp_t                    res
);

    localparam int IDX_W      = $clog2(HEAP_UNITS) + 1;
    localparam int RA_W       = $clog2(HEAP_UNITS);
    localparam int WALK_LIMIT = 4 * HEAP_UNITS + 16;
    localparam int CNT_W      = $clog2(WALK_LIMIT + 2);
    localparam int NEED_W     = ffa_pkg::NEED_W;
    localparam int SUM_W      = ffa_pkg::BYTES_W + 1;
    localparam int REC_K      = 24;
    localparam int REC_M      = ((1 << REC_K) + UNIT_BYTES - 1) / UNIT_BYTES;
    localparam int REC_W      = $clog2(REC_M + 1);
    localparam int PROD_W     = SUM_W + REC_W;
    localparam int CW         = ((IDX_W > NEED_W) ? IDX_W : NEED_W) + 2;
    localparam int ADDR_W     = ffa_pkg::ADDR_W;

    localparam logic [IDX_W-1:0] SENT = IDX_W'(HEAP_UNITS);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_NEED    = 4'd1;
    localparam logic [3:0] ST_AS_RD   = 4'd2;
    localparam logic [3:0] ST_AS_CHK  = 4'd3;
    localparam logic [3:0] ST_AW_RD   = 4'd4;
    localparam logic [3:0] ST_AW_CHK  = 4'd5;
    localparam logic [3:0] ST_SPLIT   = 4'd6;
    localparam logic [3:0] ST_GROW    = 4'd7;
    localparam logic [3:0] ST_INS_RD  = 4'd8;
    localparam logic [3:0] ST_INS_CHK = 4'd9;
    localparam logic [3:0] ST_INS_QRD = 4'd10;
    localparam logic [3:0] ST_INS_QCK = 4'd11;
    localparam logic [3:0] ST_INS_HCK = 4'd12;
    localparam logic [3:0] ST_INS_PW  = 4'd13;
    localparam logic [3:0] ST_OUT     = 4'd14;

    // Ordering key: sentinel below every pool unit
    function automatic logic [IDX_W:0] key_of(input logic [IDX_W-1:0] i);
        return (i < SENT) ? ({1'b0, i} + 1'b1) : '0;
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]    p_reg, p_next;
    logic [IDX_W-1:0]    q_reg, q_next;
    logic [IDX_W-1:0]    hb_reg, hb_next;
    logic [IDX_W-1:0]    szp_reg, szp_next;
    logic [IDX_W-1:0]    nsz_reg, nsz_next;
    logic [IDX_W-1:0]    nnx_reg, nnx_next;
    logic [IDX_W-1:0]    rover_reg, rover_next;
    logic [IDX_W-1:0]    snx_reg, snx_next;
    logic [IDX_W-1:0]    brk_reg, brk_next;
    logic                started_reg, started_next;
    logic                from_grow_reg, from_grow_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    icnt_reg, icnt_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                res_ok_reg, res_ok_next;
    logic                rd_sent_reg, rd_sent_next;

    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    nx_rdata, sz_rdata, nxd, szd;
    logic                nx_wr, sz_wr;
    logic [IDX_W-1:0]    nx_widx, nx_wval, sz_widx, sz_wval;
    logic                nx_we, sz_we;
    logic [CW-1:0]       amt;
    logic [IDX_W:0]      kp, kq, kb;

    // Node memories: link and size per unit
    ffa_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_UNITS)) u_next_ram (
        .clk   (aclk),
        .we    (nx_we),
        .waddr (nx_widx[RA_W-1:0]),
        .wdata (nx_wval),
        .raddr (rd_idx[RA_W-1:0]),
        .rdata (nx_rdata)
    );

    ffa_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_UNITS)) u_size_ram (
        .clk   (aclk),
        .we    (sz_we),
        .waddr (sz_widx[RA_W-1:0]),
        .wdata (sz_wval),
        .raddr (rd_idx[RA_W-1:0]),
        .rdata (sz_rdata)
    );

    // Sentinel reads come from registers
    assign nxd = rd_sent_reg ? snx_reg : nx_rdata;
    assign szd = rd_sent_reg ? '0 : sz_rdata;

    assign kp  = key_of(p_reg);
    assign kq  = key_of(nxd);
    assign kb  = key_of(hb_reg);
    assign amt = (CW'(need_reg) > CW'(min_grow)) ? CW'(need_reg) : CW'(min_grow);

    assign req_ready       = (state_reg == ST_IDLE);
    assign res_valid       = (state_reg == ST_OUT);
    assign res.result_addr = res_addr_reg;
    assign res.ok          = res_ok_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        hb_next        = hb_reg;
        szp_next       = szp_reg;
        nsz_next       = nsz_reg;
        nnx_next       = nnx_reg;
        rover_next     = rover_reg;
        snx_next       = snx_reg;
        brk_next       = brk_reg;
        started_next   = started_reg;
        from_grow_next = from_grow_reg;
        need_next      = need_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        icnt_next      = icnt_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        rd_idx         = p_reg;
        nx_wr          = 1'b0;
        nx_widx        = p_reg;
        nx_wval        = '0;
        sz_wr          = 1'b0;
        sz_widx        = p_reg;
        sz_wval        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    prod_next = PROD_W'((SUM_W'(req.request_bytes)
                                         + SUM_W'(UNIT_BYTES - 1)))
                                * PROD_W'(REC_M);
                    if (req.kind == ffa_pkg::KIND_FREE) begin
                        res_addr_next = '0;
                        res_ok_next   = 1'b1;
                        if (started_reg && req.block_addr != '0
                            && 32'(req.block_addr) <= 32'(HEAP_UNITS)) begin
                            hb_next        = IDX_W'(req.block_addr) - 1'b1;
                            p_next         = rover_reg;
                            icnt_next      = '0;
                            from_grow_next = 1'b0;
                            state_next     = ST_INS_RD;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        state_next = ST_NEED;
                    end
                end
            end
            ST_NEED: begin
                need_next = NEED_W'(prod_reg >> REC_K) + 1'b1;
                if (!started_reg) begin
                    snx_next     = SENT;
                    rover_next   = SENT;
                    started_next = 1'b1;
                end
                cnt_next   = '0;
                state_next = ST_AS_RD;
            end
            ST_AS_RD: begin
                rd_idx     = rover_reg;
                prev_next  = rover_reg;
                state_next = ST_AS_CHK;
            end
            ST_AS_CHK: begin
                p_next     = nxd;
                state_next = ST_AW_RD;
            end
            ST_AW_RD: begin
                rd_idx     = p_reg;
                state_next = ST_AW_CHK;
            end
            ST_AW_CHK: begin
                if (CW'(szd) >= CW'(need_reg)) begin
                    rover_next = prev_reg;
                    if (CW'(szd) == CW'(need_reg)) begin
                        // exact fit: unlink
                        nx_wr         = 1'b1;
                        nx_widx       = prev_reg;
                        nx_wval       = nxd;
                        res_addr_next = ADDR_W'(p_reg + 1'b1);
                        res_ok_next   = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        // split: shrink head, hand out tail
                        sz_wr      = 1'b1;
                        sz_widx    = p_reg;
                        sz_wval    = szd - IDX_W'(need_reg);
                        q_next     = p_reg + (szd - IDX_W'(need_reg));
                        state_next = ST_SPLIT;
                    end
                end else if (p_reg == rover_reg) begin
                    state_next = ST_GROW;
                end else if (cnt_reg == CNT_W'(WALK_LIMIT)) begin
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                    state_next    = ST_OUT;
                end else begin
                    prev_next  = p_reg;
                    p_next     = nxd;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_AW_RD;
                end
            end
            ST_SPLIT: begin
                sz_wr         = 1'b1;
                sz_widx       = q_reg;
                sz_wval       = IDX_W'(need_reg);
                res_addr_next = ADDR_W'(q_reg + 1'b1);
                res_ok_next   = 1'b1;
                state_next    = ST_OUT;
            end
            ST_GROW: begin
                if (CW'(brk_reg) + amt > CW'(HEAP_UNITS)) begin
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                    state_next    = ST_OUT;
                end else begin
                    hb_next        = brk_reg;
                    brk_next       = brk_reg + IDX_W'(amt);
                    sz_wr          = 1'b1;
                    sz_widx        = brk_reg;
                    sz_wval        = IDX_W'(amt);
                    p_next         = rover_reg;
                    icnt_next      = '0;
                    from_grow_next = 1'b1;
                    state_next     = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                rd_idx     = p_reg;
                state_next = ST_INS_CHK;
            end
            ST_INS_CHK: begin
                if (icnt_reg > CNT_W'(WALK_LIMIT)) begin
                    // runaway walk: drop the insert
                    res_addr_next = '0;
                    res_ok_next   = !from_grow_reg;
                    state_next    = ST_OUT;
                end else if ((kb > kp && kb < kq) || (kp >= kq && (kb > kp || kb < kq))) begin
                    q_next     = nxd;
                    szp_next   = szd;
                    state_next = ST_INS_QRD;
                end else begin
                    p_next     = nxd;
                    icnt_next  = icnt_reg + 1'b1;
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_QRD: begin
                rd_idx     = q_reg;
                state_next = ST_INS_QCK;
            end
            ST_INS_QCK: begin
                nsz_next   = szd;
                nnx_next   = nxd;
                rd_idx     = hb_reg;
                state_next = ST_INS_HCK;
            end
            ST_INS_HCK: begin
                // merge with upper neighbor
                nx_wr   = 1'b1;
                nx_widx = hb_reg;
                if (q_reg < SENT && {1'b0, hb_reg} + {1'b0, szd} == {1'b0, q_reg}) begin
                    sz_wr    = 1'b1;
                    sz_widx  = hb_reg;
                    sz_wval  = szd + nsz_reg;
                    nx_wval  = nnx_reg;
                    nsz_next = szd + nsz_reg;
                    nnx_next = nnx_reg;
                end else begin
                    nx_wval  = q_reg;
                    nsz_next = szd;
                    nnx_next = q_reg;
                end
                state_next = ST_INS_PW;
            end
            ST_INS_PW: begin
                // merge with lower neighbor
                nx_wr   = 1'b1;
                nx_widx = p_reg;
                if (p_reg < SENT && {1'b0, p_reg} + {1'b0, szp_reg} == {1'b0, hb_reg}) begin
                    sz_wr   = 1'b1;
                    sz_widx = p_reg;
                    sz_wval = szp_reg + nsz_reg;
                    nx_wval = nnx_reg;
                end else begin
                    nx_wval = hb_reg;
                end
                rover_next = p_reg;
                if (!from_grow_reg) begin
                    res_addr_next = '0;
                    res_ok_next   = 1'b1;
                    state_next    = ST_OUT;
                end else if (cnt_reg == CNT_W'(WALK_LIMIT)) begin
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                    state_next    = ST_OUT;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_AS_RD;
                end
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Sentinel link lives in a register
        if (nx_wr && nx_widx >= SENT) begin
            snx_next = nx_wval;
        end
        rd_sent_next = (rd_idx >= SENT);
    end

    assign nx_we = nx_wr && (nx_widx < SENT);
    assign sz_we = sz_wr && (sz_widx < SENT);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rover_reg   <= SENT;
            snx_reg     <= SENT;
            brk_reg     <= '0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rover_reg   <= rover_next;
            snx_reg     <= snx_next;
            brk_reg     <= brk_next;
            started_reg <= started_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        prev_reg      <= prev_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        hb_reg        <= hb_next;
        szp_reg       <= szp_next;
        nsz_reg       <= nsz_next;
        nnx_reg       <= nnx_next;
        from_grow_reg <= from_grow_next;
        need_reg      <= need_next;
        prod_reg      <= prod_next;
        cnt_reg       <= cnt_next;
        icnt_reg      <= icnt_next;
        res_addr_reg  <= res_addr_next;
        res_ok_reg    <= res_ok_next;
        rd_sent_reg   <= rd_sent_next;
    end

    a_brk_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        brk_reg <= SENT)
        else $error("break beyond pool");

    a_brk_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> brk_reg >= $past(brk_reg))
        else $error("break shrank");

    a_started_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |=> started_reg)
        else $error("list start flag dropped");

    a_need_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AW_CHK || state_reg == ST_GROW) |-> need_reg != '0)
        else $error("zero unit request in walk");

endmodule

// File: hdl/first_fit_free_list_allocator_top.sv
// First-fit free-list heap allocator.
// Input channel s_valid/s_ready/s_req carries one request: kind selects
// allocate (size in request_bytes) or free (data-start unit in block_addr).
// Result channel m_valid/m_ready/m_rsp returns one response per request:
// result_addr is the allocated data-start unit (0 for free and failure),
// ok is low only when an allocate could not be served from the pool.
// cfg_wr_en/cfg_wr_data write the minimum break growth in units.
// A free walks the list to its insert point (an ignored free walks none);
// an allocate walks for a fit, and each break growth adds an insert walk.
// Each node costs one read of the link/size memories, whose read data is
// registered.
// One request is in work at a time; the next is accepted once the response
// has moved into the output register, even while that register waits.
// Reset clears the list state; node memories need no clearing pass.
// While the receiver stalls, the response holds in the output register.
module first_fit_free_list_allocator_top #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ffa_pkg::req_t                  s_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ffa_pkg::rsp_t                  m_rsp,
    input  logic                           cfg_wr_en,
    input  logic [ffa_pkg::MIN_GROW_W-1:0] cfg_wr_data
);

    logic [ffa_pkg::MIN_GROW_W-1:0] min_grow_reg;
    logic                           m_valid_reg;
    ffa_pkg::rsp_t                  m_rsp_reg;
    logic                           res_valid, res_ready;
    ffa_pkg::rsp_t                  res;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_grow_reg <= ffa_pkg::MIN_GROW_RST;
        end else if (cfg_wr_en) begin
            min_grow_reg <= cfg_wr_data;
        end
    end

    ffa_core #(.HEAP_UNITS(HEAP_UNITS), .UNIT_BYTES(UNIT_BYTES)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_req),
        .min_grow  (min_grow_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: take a response when empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_rsp_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

// File: sim/first_fit_free_list_allocator_checker.sv
module first_fit_free_list_allocator_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  ffa_pkg::req_t                  s_req,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  ffa_pkg::rsp_t                  m_rsp,
    input  logic                           cfg_wr_en,
    input  logic [ffa_pkg::MIN_GROW_W-1:0] cfg_wr_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SENT_IDX   = ffa_pkg::HEAP_UNITS_DEF;
    localparam int WALK_LIMIT = ffa_pkg::HEAP_UNITS_DEF * 4 + 16;

    // Shadow heap: per-unit link and size, plus list head state
    logic [12:0] link_mem [ffa_pkg::HEAP_UNITS_DEF];
    logic [12:0] size_mem [ffa_pkg::HEAP_UNITS_DEF];
    int          break_units;
    int          rover_idx;
    int          sentinel_link;
    bit          heap_started;
    int          grow_units;

    ffa_pkg::rsp_t rsp_expected_q[$];

    assign pending = rsp_expected_q.size();

    function automatic int link_of(int i);
        return (i < SENT_IDX) ? int'(link_mem[i]) : sentinel_link;
    endfunction

    function automatic int size_of(int i);
        return (i < SENT_IDX) ? int'(size_mem[i]) : 0;
    endfunction

    function automatic void set_link(int i, int v);
        if (i < SENT_IDX) link_mem[i] = v[12:0];
        else sentinel_link = v;
    endfunction

    function automatic void set_size(int i, int v);
        if (i < SENT_IDX) size_mem[i] = v[12:0];
    endfunction

    function automatic int order_key(int i);
        return (i < SENT_IDX) ? i + 1 : 0;
    endfunction

    // Link a block into the address-ordered list, merging with both neighbors
    function automatic bit link_block(int hb);
        int p, q, kb;
        bit found;
        p = rover_idx;
        q = 0;
        kb = order_key(hb);
        found = 0;
        for (int n = 0; n <= WALK_LIMIT; n++) begin
            q = link_of(p);
            if (kb > order_key(p) && kb < order_key(q)) begin
                found = 1;
                break;
            end
            if (order_key(p) >= order_key(q) && (kb > order_key(p) || kb < order_key(q))) begin
                found = 1;
                break;
            end
            p = q;
        end
        if (!found) return 0;
        if (q < SENT_IDX && hb + size_of(hb) == q) begin
            set_size(hb, size_of(hb) + size_of(q));
            set_link(hb, link_of(q));
        end else begin
            set_link(hb, q);
        end
        if (p < SENT_IDX && p + size_of(p) == hb) begin
            set_size(p, size_of(p) + size_of(hb));
            set_link(p, link_of(hb));
        end else begin
            set_link(p, hb);
        end
        rover_idx = p;
        return 1;
    endfunction

    // Extend the break and hand the new space to the list
    function automatic bit extend_break(int need);
        int amt, hb;
        amt = (need < grow_units) ? grow_units : need;
        if (break_units + amt > ffa_pkg::HEAP_UNITS_DEF) return 0;
        hb = break_units;
        break_units += amt;
        set_size(hb, amt);
        return link_block(hb);
    endfunction

    // Work out the response to one request and update the shadow heap
    function automatic ffa_pkg::rsp_t serve_request(ffa_pkg::req_t r);
        ffa_pkg::rsp_t res;
        int need, prev, p, addr;
        res.result_addr = '0;
        res.ok = 1'b1;
        addr = int'(r.block_addr);
        if (r.kind == ffa_pkg::KIND_FREE) begin
            if (heap_started && addr != 0) void'(link_block(addr - 1));
            return res;
        end
        need = (int'(r.request_bytes) + ffa_pkg::UNIT_BYTES_DEF - 1)
               / ffa_pkg::UNIT_BYTES_DEF + 1;
        if (!heap_started) begin
            sentinel_link = SENT_IDX;
            rover_idx = SENT_IDX;
            heap_started = 1;
        end
        prev = rover_idx;
        p = link_of(prev);
        for (int n = 0; n <= WALK_LIMIT; n++) begin
            if (size_of(p) >= need) begin
                if (size_of(p) == need) begin
                    set_link(prev, link_of(p));
                end else begin
                    set_size(p, size_of(p) - need);
                    p += size_of(p);
                    set_size(p, need);
                end
                rover_idx = prev;
                res.result_addr = ffa_pkg::ADDR_W'(p + 1);
                return res;
            end
            if (p == rover_idx) begin
                if (!extend_break(need)) break;
                p = rover_idx;
            end
            prev = p;
            p = link_of(p);
        end
        res.result_addr = '0;
        res.ok = 1'b0;
        return res;
    endfunction

    // Track config, predict on each request, compare each response
    always @(posedge aclk) begin
        ffa_pkg::rsp_t want;
        if (!aresetn) begin
            break_units = 0;
            rover_idx = SENT_IDX;
            sentinel_link = SENT_IDX;
            heap_started = 0;
            grow_units = int'(ffa_pkg::MIN_GROW_RST);
            fail_count = 0;
            rsp_expected_q.delete();
        end else begin
            if (cfg_wr_en) grow_units = int'(cfg_wr_data);
            if (s_valid && s_ready) rsp_expected_q.push_back(serve_request(s_req));
            if (m_valid && m_ready) begin
                if (rsp_expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected response addr=%0d ok=%0b",
                             $realtime, m_rsp.result_addr, m_rsp.ok);
                end else begin
                    want = rsp_expected_q.pop_front();
                    if (want.result_addr !== m_rsp.result_addr) begin
                        fail_count++;
                        $display("%0t: result_addr expected %0d actual %0d",
                                 $realtime, want.result_addr, m_rsp.result_addr);
                    end
                    if (want.ok !== m_rsp.ok) begin
                        fail_count++;
                        $display("%0t: ok expected %0b actual %0b",
                                 $realtime, want.ok, m_rsp.ok);
                    end
                end
            end
        end
    end

endmodule

// File: sim/first_fit_free_list_allocator_top_test.sv
module first_fit_free_list_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000000;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    ffa_pkg::req_t                  s_req;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    ffa_pkg::rsp_t                  m_rsp;
    logic                           cfg_wr_en;
    logic [ffa_pkg::MIN_GROW_W-1:0] cfg_wr_data;

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    int  in_flight = 0;
    int  burst_left;
    int  stall_mode = 0;
    bit  kind_q[$];
    int  live_blocks[$];

    first_fit_free_list_allocator_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    first_fit_free_list_allocator_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the response channel in changing modes
    always @(posedge aclk) begin
        if (($urandom % 64) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom % 2) == 0;
            default: m_ready <= ($urandom % 6) == 0;
        endcase
    end

    // Count requests in flight across both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_flight <= 0;
        end else begin
            in_flight <= in_flight + int'(s_valid && s_ready) - int'(m_valid && m_ready);
        end
    end

    // Collect granted blocks so later frees hit live headers
    always @(posedge aclk) begin
        bit k;
        if (aresetn && m_valid && m_ready) begin
            k = kind_q.pop_front();
            if (k == ffa_pkg::KIND_ALLOC && m_rsp.ok && m_rsp.result_addr != 0)
                live_blocks.push_back(int'(m_rsp.result_addr));
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(bit kind, int nbytes, int addr);
        ffa_pkg::req_t r;
        r.kind = kind;
        r.request_bytes = ffa_pkg::BYTES_W'(nbytes);
        r.block_addr = ffa_pkg::ADDR_W'(addr);
        s_valid <= 1'b1;
        s_req <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        kind_q.push_back(kind);
    endtask

    // Insert an idle gap between bursts
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic alloc_bytes(int nbytes);
        send_request(ffa_pkg::KIND_ALLOC, nbytes, $urandom_range(0, 4095));
    endtask

    // Release a randomly chosen live block
    task automatic free_live();
        int idx, addr;
        idx = $urandom_range(0, live_blocks.size() - 1);
        addr = live_blocks[idx];
        live_blocks.delete(idx);
        send_request(ffa_pkg::KIND_FREE, $urandom_range(0, 65535), addr);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0 || pending != 0) @(posedge aclk);
    endtask

    task automatic write_grow(int units);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ffa_pkg::MIN_GROW_W'(units);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n_req);
        int pick;
        for (int i = 0; i < n_req; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45 && live_blocks.size() != 0) free_live();
            else if (pick < 48) alloc_bytes($urandom_range(0, 65535));
            else if (pick < 50) send_request(ffa_pkg::KIND_FREE, $urandom_range(0, 65535), 0);
            else if (pick < 60) alloc_bytes($urandom_range(0, 2000));
            else alloc_bytes($urandom_range(0, 160));
            pace_sender();
        end
    endtask

    initial begin
        int grow_set[5];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        burst_left = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: free before the heap exists, size extremes, exact fits, merges
        send_request(ffa_pkg::KIND_FREE, 0, 5);
        alloc_bytes(65535);
        alloc_bytes(0);
        send_request(ffa_pkg::KIND_FREE, 65535, 0);
        alloc_bytes(1);
        alloc_bytes(16);
        alloc_bytes(17);
        alloc_bytes(32);
        alloc_bytes(1000);
        alloc_bytes(16000);
        alloc_bytes(65535);
        wait_drained();
        free_live();
        free_live();
        free_live();
        alloc_bytes(16);
        alloc_bytes(0);
        wait_drained();
        while (live_blocks.size() != 0) free_live();
        alloc_bytes(4094 * 16);
        alloc_bytes(4096 * 16);

        // Random phases under several growth settings
        grow_set = '{1, 4096, 7, $urandom_range(2, 300), 1024};
        foreach (grow_set[g]) begin
            write_grow(grow_set[g]);
            random_phase(400);
        end
        wait_drained();
        repeat (200) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
